/* src/bpa_pkg.sv */
package bpa_pkg;

  localparam int unsigned MAX_PAGES_DEF  = 1024;
  localparam int unsigned PAGE_SHIFT_DEF = 12;
  localparam int unsigned CFG_W          = 11;
  localparam int unsigned TOTAL_RST      = 1024;
  localparam int unsigned CMD_W          = 3;
  localparam int unsigned ADDR_W         = 32;
  localparam int unsigned PIDX_W         = 16;
  localparam int unsigned PADDR_W        = 22;
  localparam int unsigned USED_W         = 11;

  // Request opcodes. Codes 6 and 7 are not defined and fail.
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_RESERVE = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_QUERY   = 3'd4,
    CMD_RESET   = 3'd5
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISP,
    ST_CLR,
    ST_CARVE,
    ST_ALC_SCAN,
    ST_UL_RD,
    ST_UL_WR,
    ST_SPLIT,
    ST_PUSH_A,
    ST_PUSH_B,
    ST_RL_RD,
    ST_RL_CHK,
    ST_MRG,
    ST_WALK,
    ST_WALK_ADV,
    ST_RS_RD,
    ST_RS_CHK,
    ST_RS_ORD,
    ST_PG_DONE,
    ST_Q_RD,
    ST_Q_CHK,
    ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LATCH,
    OP_RST_INIT,
    OP_CLR_STEP,
    OP_CARVE_STEP,
    OP_SET_READY,
    OP_ORD_ZERO,
    OP_ORD_INC,
    OP_ALC_TAKE,
    OP_UL_RD,
    OP_UL_WR,
    OP_SPLIT,
    OP_SPLIT_FIN,
    OP_PUSH_A,
    OP_PUSH_B,
    OP_RD_PG,
    OP_RL_TAKE,
    OP_MRG_SETUP,
    OP_PUSH_CUR,
    OP_WALK_RD,
    OP_WALK_ADV,
    OP_RS_SETUP,
    OP_CLR_OK,
    OP_FREE_INIT,
    OP_RANGE_INIT,
    OP_QRY_INIT,
    OP_PG_NEXT,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic is_resv;
    logic is_rel;
    logic is_query;
    logic is_reset;
    logic ready;
    logic rst_zero;
    logic addr_ok;
    logic range_in;
    logic query_ok;
    logic clr_last;
    logic rem_zero;
    logic ord_gt_top;
    logic ord_ge_top;
    logic ord_zero;
    logic head_valid;
    logic bud_oob;
    logic walk_null;
    logic walk_hit;
    logic rd_used;
    logic pg_last;
    logic out_free;
  } bpa_stat_t;

endpackage

/* src/bpa_ctrl.sv */
module bpa_ctrl import bpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  bpa_stat_t stat,
  output logic      in_stall,
  output dp_op_t    op
);

  state_t state_r;
  state_t state_nxt;
  logic   is_rls;

  assign is_rls   = stat.is_free || stat.is_rel;
  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISP;
      end
      ST_DISP: begin
        priority if (stat.is_reset) state_nxt = stat.rst_zero ? ST_FIN : ST_CLR;
        else if (!stat.ready)       state_nxt = ST_FIN;
        else if (stat.is_alloc)     state_nxt = ST_ALC_SCAN;
        else if (stat.is_free)      state_nxt = stat.addr_ok ? ST_RL_RD : ST_FIN;
        else if (stat.is_resv)      state_nxt = stat.range_in ? ST_RS_RD : ST_FIN;
        else if (stat.is_rel)       state_nxt = stat.range_in ? ST_RL_RD : ST_FIN;
        else if (stat.is_query)     state_nxt = stat.query_ok ? ST_Q_RD : ST_FIN;
        else                        state_nxt = ST_FIN;
      end
      ST_CLR: begin
        if (stat.clr_last) state_nxt = ST_CARVE;
      end
      ST_CARVE: begin
        state_nxt = stat.rem_zero ? ST_FIN : ST_PUSH_A;
      end
      ST_ALC_SCAN: begin
        priority if (stat.ord_gt_top) state_nxt = ST_FIN;
        else if (stat.head_valid)     state_nxt = ST_UL_RD;
        else                          state_nxt = ST_ALC_SCAN;
      end
      ST_UL_RD:  state_nxt = ST_UL_WR;
      ST_UL_WR:  state_nxt = is_rls ? ST_MRG : ST_SPLIT;
      ST_SPLIT: begin
        if (stat.ord_zero) state_nxt = stat.is_alloc ? ST_FIN : ST_PG_DONE;
        else               state_nxt = ST_PUSH_A;
      end
      ST_PUSH_A: state_nxt = ST_PUSH_B;
      ST_PUSH_B: begin
        priority if (stat.is_reset) state_nxt = ST_CARVE;
        else if (is_rls)            state_nxt = ST_PG_DONE;
        else                        state_nxt = ST_SPLIT;
      end
      ST_RL_RD:  state_nxt = ST_RL_CHK;
      ST_RL_CHK: state_nxt = stat.rd_used ? ST_MRG : ST_PG_DONE;
      ST_MRG: begin
        if (stat.ord_ge_top || stat.bud_oob) state_nxt = ST_PUSH_A;
        else                                 state_nxt = ST_WALK;
      end
      ST_WALK: begin
        priority if (stat.walk_null) state_nxt = is_rls ? ST_PUSH_A : ST_RS_ORD;
        else if (stat.walk_hit)      state_nxt = ST_UL_RD;
        else                         state_nxt = ST_WALK_ADV;
      end
      ST_WALK_ADV: state_nxt = ST_WALK;
      ST_RS_RD:    state_nxt = ST_RS_CHK;
      ST_RS_CHK:   state_nxt = stat.rd_used ? ST_PG_DONE : ST_RS_ORD;
      ST_RS_ORD:   state_nxt = stat.ord_gt_top ? ST_FIN : ST_WALK;
      ST_PG_DONE: begin
        priority if (stat.is_free || stat.pg_last) state_nxt = ST_FIN;
        else if (stat.is_resv)                     state_nxt = ST_RS_RD;
        else                                       state_nxt = ST_RL_RD;
      end
      ST_Q_RD: state_nxt = ST_Q_CHK;
      ST_Q_CHK: begin
        if (stat.rd_used || stat.pg_last) state_nxt = ST_FIN;
        else                              state_nxt = ST_Q_RD;
      end
      ST_FIN: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    op = OP_NOP;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) op = OP_LATCH;
      end
      ST_DISP: begin
        priority if (stat.is_reset) begin
          if (!stat.rst_zero) op = OP_RST_INIT;
        end else if (!stat.ready) begin
          op = OP_NOP;
        end else if (stat.is_alloc) begin
          op = OP_ORD_ZERO;
        end else if (stat.is_free) begin
          if (stat.addr_ok) op = OP_FREE_INIT;
        end else if (stat.is_resv || stat.is_rel) begin
          op = OP_RANGE_INIT;
        end else if (stat.is_query) begin
          op = OP_QRY_INIT;
        end else begin
          op = OP_NOP;
        end
      end
      ST_CLR:      op = OP_CLR_STEP;
      ST_CARVE:    op = stat.rem_zero ? OP_SET_READY : OP_CARVE_STEP;
      ST_ALC_SCAN: begin
        if (!stat.ord_gt_top) op = stat.head_valid ? OP_ALC_TAKE : OP_ORD_INC;
      end
      ST_UL_RD:    op = OP_UL_RD;
      ST_UL_WR:    op = OP_UL_WR;
      ST_SPLIT:    op = stat.ord_zero ? OP_SPLIT_FIN : OP_SPLIT;
      ST_PUSH_A:   op = OP_PUSH_A;
      ST_PUSH_B:   op = OP_PUSH_B;
      ST_RL_RD:    op = OP_RD_PG;
      ST_RL_CHK: begin
        if (stat.rd_used) op = OP_RL_TAKE;
      end
      ST_MRG: begin
        op = (stat.ord_ge_top || stat.bud_oob) ? OP_PUSH_CUR : OP_MRG_SETUP;
      end
      ST_WALK: begin
        priority if (stat.walk_null) op = is_rls ? OP_PUSH_CUR : OP_ORD_INC;
        else if (stat.walk_hit)      op = OP_NOP;
        else                         op = OP_WALK_RD;
      end
      ST_WALK_ADV: op = OP_WALK_ADV;
      ST_RS_RD:    op = OP_RD_PG;
      ST_RS_CHK: begin
        if (!stat.rd_used) op = OP_ORD_ZERO;
      end
      ST_RS_ORD:   op = stat.ord_gt_top ? OP_CLR_OK : OP_RS_SETUP;
      ST_PG_DONE: begin
        if (!stat.is_free) op = OP_PG_NEXT;
      end
      ST_Q_RD:     op = OP_RD_PG;
      ST_Q_CHK: begin
        if (!stat.rd_used) op = OP_PG_NEXT;
      end
      ST_FIN: begin
        if (stat.out_free) op = OP_EMIT;
      end
      default: op = OP_NOP;
    endcase
  end

endmodule

/* src/bpa_dp.sv */
module bpa_dp import bpa_pkg::*; #(
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_op_t             op,
  output bpa_stat_t          stat,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [ADDR_W-1:0]  in_free_address,
  input  logic [PIDX_W-1:0]  in_first_page,
  input  logic [PIDX_W-1:0]  in_page_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic [PADDR_W-1:0] out_page_address,
  output logic               out_range_free,
  output logic [USED_W-1:0]  out_used_pages
);

  localparam int unsigned PW   = $clog2(MAX_PAGES);
  localparam int unsigned LW   = PW + 1;
  localparam int unsigned NORD = PW + 1;
  localparam int unsigned HW   = $clog2(NORD);
  localparam int unsigned OW   = $clog2(PW + 2);
  localparam logic [LW-1:0] NIL = LW'(1) << PW;

  // Highest set bit of a nonzero value.
  function automatic logic [OW-1:0] msb_idx(input logic [LW-1:0] v);
    logic [OW-1:0] r;
    r = '0;
    for (int i = 0; i < LW; i++) begin
      if (v[i]) r = OW'(i);
    end
    return r;
  endfunction

  // Lowest set bit; zero counts as aligned to every order.
  function automatic logic [OW-1:0] lsb_idx(input logic [LW-1:0] v);
    logic [OW-1:0] r;
    r = OW'(PW);
    for (int i = LW - 1; i >= 0; i--) begin
      if (v[i]) r = OW'(i);
    end
    return r;
  endfunction

  // Control state.
  logic [CFG_W-1:0] total_r;
  logic [LW-1:0]    managed_r;
  logic [OW-1:0]    top_r;
  logic             ready_r;
  logic [LW-1:0]    cnt_r;
  logic             out_valid_r;

  // Working registers.
  logic [LW-1:0]     heads_r [NORD];
  logic [CMD_W-1:0]  cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PIDX_W-1:0] first_r;
  logic [PIDX_W-1:0] count_r;
  logic [LW-1:0]     pg_r;
  logic [LW-1:0]     end_r;
  logic [LW-1:0]     blk_r;
  logic [LW-1:0]     cur_r;
  logic [LW-1:0]     push_r;
  logic [LW-1:0]     walk_r;
  logic [LW-1:0]     rem_r;
  logic [OW-1:0]     ord_r;
  logic [PW-1:0]     clr_r;
  logic              res_ok_r;
  logic              res_rf_r;
  logic [PADDR_W-1:0] res_pa_r;
  logic              out_ok_r;
  logic              out_rf_r;
  logic [PADDR_W-1:0] out_pa_r;
  logic [USED_W-1:0] out_used_r;

  // Page stores.
  logic [LW-1:0] next_link_r  [MAX_PAGES];
  logic [LW-1:0] prev_link_r  [MAX_PAGES];
  logic [OW-1:0] block_ord_r  [MAX_PAGES];
  logic          page_used_r  [MAX_PAGES];
  logic [LW-1:0] rd_nxt_r;
  logic [LW-1:0] rd_prv_r;
  logic [OW-1:0] rd_ord_r;
  logic          rd_used_r;

  // Combinational helpers.
  logic [LW-1:0]     t_sat;
  logic [LW-1:0]     head_cur;
  logic [LW-1:0]     bud;
  logic [PIDX_W:0]   range_sum;
  logic [ADDR_W-1:0] idx32;
  logic [ADDR_W-1:0] pmask;
  logic [OW-1:0]     o_dec;
  logic [LW-1:0]     right;
  logic [LW-1:0]     pg_inc;
  logic [OW-1:0]     o_car;
  logic [OW-1:0]     o_ctz;
  logic [OW-1:0]     o_rem;
  logic [LW-1:0]     car_sz;
  logic [LW-1:0]     rs_mask;
  logic [63:0]       pa_wide;
  logic              is_rls;

  logic          nl_we;
  logic [PW-1:0] nl_wa;
  logic [LW-1:0] nl_wd;
  logic          pl_we;
  logic [PW-1:0] pl_wa;
  logic [LW-1:0] pl_wd;
  logic          om_we;
  logic [PW-1:0] om_wa;
  logic [OW-1:0] om_wd;
  logic          um_we;
  logic [PW-1:0] um_wa;
  logic          um_wd;
  logic [PW-1:0] rd_a;

  assign t_sat    = (32'(total_r) > 32'(MAX_PAGES)) ? LW'(MAX_PAGES) : LW'(total_r);
  assign head_cur = (ord_r <= OW'(PW)) ? heads_r[ord_r[HW-1:0]] : NIL;
  assign bud      = cur_r ^ (LW'(1) << ord_r);
  assign range_sum = {1'b0, first_r} + {1'b0, count_r};
  assign idx32    = addr_r >> PAGE_SHIFT;
  assign pmask    = ADDR_W'((64'(1) << PAGE_SHIFT) - 64'(1));
  assign o_dec    = ord_r - OW'(1);
  assign right    = blk_r + (LW'(1) << o_dec);
  assign pg_inc   = pg_r + LW'(1);
  assign o_ctz    = lsb_idx(cur_r);
  assign o_rem    = msb_idx(rem_r);
  assign car_sz   = LW'(1) << o_car;
  assign rs_mask  = ~((LW'(1) << ord_r) - LW'(1));
  assign pa_wide  = 64'(blk_r) << PAGE_SHIFT;
  assign is_rls   = (cmd_r == CMD_FREE) || (cmd_r == CMD_RELEASE);

  // Largest block that fits the remainder, is aligned and stays within the top order.
  always_comb begin
    o_car = top_r;
    if (o_ctz < o_car) o_car = o_ctz;
    if (o_rem < o_car) o_car = o_rem;
  end

  always_comb begin
    stat.is_alloc   = (cmd_r == CMD_ALLOC);
    stat.is_free    = (cmd_r == CMD_FREE);
    stat.is_resv    = (cmd_r == CMD_RESERVE);
    stat.is_rel     = (cmd_r == CMD_RELEASE);
    stat.is_query   = (cmd_r == CMD_QUERY);
    stat.is_reset   = (cmd_r == CMD_RESET);
    stat.ready      = ready_r;
    stat.rst_zero   = (total_r == '0);
    stat.addr_ok    = ((addr_r & pmask) == '0) && (idx32 < 32'(managed_r));
    stat.range_in   = (32'(first_r) < 32'(managed_r)) && (count_r != '0);
    stat.query_ok   = (count_r != '0) && (32'(first_r) < 32'(managed_r)) &&
                      (32'(range_sum) <= 32'(managed_r));
    stat.clr_last   = (clr_r == PW'(MAX_PAGES - 1));
    stat.rem_zero   = (rem_r == '0);
    stat.ord_gt_top = (ord_r > top_r);
    stat.ord_ge_top = (ord_r >= top_r);
    stat.ord_zero   = (ord_r == '0);
    stat.head_valid = !head_cur[PW];
    stat.bud_oob    = (bud >= managed_r);
    stat.walk_null  = walk_r[PW];
    stat.walk_hit   = (walk_r == blk_r);
    stat.rd_used    = rd_used_r;
    stat.pg_last    = (pg_inc == end_r);
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // Store write and read ports.
  always_comb begin
    nl_we = 1'b0;
    nl_wa = '0;
    nl_wd = NIL;
    pl_we = 1'b0;
    pl_wa = '0;
    pl_wd = NIL;
    om_we = 1'b0;
    om_wa = '0;
    om_wd = '0;
    um_we = 1'b0;
    um_wa = '0;
    um_wd = 1'b0;
    unique case (op)
      OP_UL_WR: begin
        if (!rd_prv_r[PW]) begin
          nl_we = 1'b1;
          nl_wa = rd_prv_r[PW-1:0];
          nl_wd = rd_nxt_r;
        end
        if (!rd_nxt_r[PW]) begin
          pl_we = 1'b1;
          pl_wa = rd_nxt_r[PW-1:0];
          pl_wd = rd_prv_r;
        end
      end
      OP_PUSH_A: begin
        nl_we = 1'b1;
        nl_wa = push_r[PW-1:0];
        nl_wd = head_cur;
        om_we = 1'b1;
        om_wa = push_r[PW-1:0];
        om_wd = ord_r;
        if (!head_cur[PW]) begin
          pl_we = 1'b1;
          pl_wa = head_cur[PW-1:0];
          pl_wd = push_r;
        end
      end
      OP_PUSH_B: begin
        pl_we = 1'b1;
        pl_wa = push_r[PW-1:0];
        pl_wd = NIL;
      end
      OP_SPLIT_FIN: begin
        om_we = 1'b1;
        om_wa = blk_r[PW-1:0];
        um_we = 1'b1;
        um_wa = blk_r[PW-1:0];
        um_wd = 1'b1;
      end
      OP_RL_TAKE: begin
        um_we = 1'b1;
        um_wa = pg_r[PW-1:0];
      end
      OP_CLR_STEP: begin
        om_we = 1'b1;
        om_wa = clr_r;
        um_we = 1'b1;
        um_wa = clr_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    unique case (op)
      OP_UL_RD:   rd_a = blk_r[PW-1:0];
      OP_WALK_RD: rd_a = walk_r[PW-1:0];
      default:    rd_a = pg_r[PW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (nl_we) next_link_r[nl_wa] <= nl_wd;
    if (pl_we) prev_link_r[pl_wa] <= pl_wd;
    if (om_we) block_ord_r[om_wa] <= om_wd;
    if (um_we) page_used_r[um_wa] <= um_wd;
    rd_nxt_r  <= next_link_r[rd_a];
    rd_prv_r  <= prev_link_r[rd_a];
    rd_ord_r  <= block_ord_r[rd_a];
    rd_used_r <= page_used_r[rd_a];
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= CFG_W'(TOTAL_RST);
      managed_r   <= '0;
      top_r       <= '0;
      ready_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) total_r <= cfg_wdata;
      if (op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (op)
        OP_RST_INIT: begin
          managed_r <= t_sat;
          top_r     <= msb_idx(t_sat);
          cnt_r     <= '0;
        end
        OP_SET_READY: ready_r <= 1'b1;
        OP_SPLIT_FIN: cnt_r <= cnt_r + LW'(1);
        OP_RL_TAKE: begin
          if (cnt_r != '0) cnt_r <= cnt_r - LW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    unique case (op)
      OP_LATCH: begin
        cmd_r    <= in_cmd;
        addr_r   <= in_free_address;
        first_r  <= in_first_page;
        count_r  <= in_page_count;
        res_ok_r <= 1'b0;
        res_rf_r <= 1'b0;
        res_pa_r <= '0;
      end
      OP_RST_INIT: begin
        for (int i = 0; i < NORD; i++) heads_r[i] <= NIL;
        clr_r <= '0;
        cur_r <= '0;
        rem_r <= t_sat;
      end
      OP_CLR_STEP: clr_r <= clr_r + PW'(1);
      OP_CARVE_STEP: begin
        push_r <= cur_r;
        ord_r  <= o_car;
        cur_r  <= cur_r + car_sz;
        rem_r  <= rem_r - car_sz;
      end
      OP_SET_READY: res_ok_r <= 1'b1;
      OP_ORD_ZERO:  ord_r <= '0;
      OP_ORD_INC:   ord_r <= ord_r + OW'(1);
      OP_ALC_TAKE:  blk_r <= head_cur;
      OP_UL_WR: begin
        if (rd_prv_r[PW]) heads_r[ord_r[HW-1:0]] <= rd_nxt_r;
        if (is_rls) begin
          if (blk_r < cur_r) cur_r <= blk_r;
          ord_r <= ord_r + OW'(1);
        end
      end
      OP_SPLIT: begin
        ord_r <= o_dec;
        if ((cmd_r == CMD_ALLOC) || (pg_r < right)) begin
          push_r <= right;
        end else begin
          push_r <= blk_r;
          blk_r  <= right;
        end
      end
      OP_SPLIT_FIN: begin
        if (cmd_r == CMD_ALLOC) begin
          res_ok_r <= 1'b1;
          res_pa_r <= pa_wide[PADDR_W-1:0];
        end
      end
      OP_PUSH_B: heads_r[ord_r[HW-1:0]] <= push_r;
      OP_RL_TAKE: begin
        cur_r <= pg_r;
        ord_r <= rd_ord_r;
      end
      OP_MRG_SETUP: begin
        blk_r  <= bud;
        walk_r <= head_cur;
      end
      OP_PUSH_CUR: push_r <= cur_r;
      OP_WALK_ADV: walk_r <= rd_nxt_r;
      OP_RS_SETUP: begin
        blk_r  <= pg_r & rs_mask;
        walk_r <= head_cur;
      end
      OP_CLR_OK: res_ok_r <= 1'b0;
      OP_FREE_INIT: begin
        pg_r     <= LW'(idx32);
        res_ok_r <= 1'b1;
      end
      OP_RANGE_INIT: begin
        res_ok_r <= 1'b1;
        pg_r     <= LW'(first_r);
        if (32'(range_sum) > 32'(managed_r)) end_r <= managed_r;
        else end_r <= LW'(range_sum);
      end
      OP_QRY_INIT: begin
        res_ok_r <= 1'b1;
        pg_r     <= LW'(first_r);
        end_r    <= LW'(range_sum);
      end
      OP_PG_NEXT: begin
        pg_r <= pg_inc;
        if ((cmd_r == CMD_QUERY) && (pg_inc == end_r)) res_rf_r <= 1'b1;
      end
      OP_EMIT: begin
        out_ok_r   <= res_ok_r;
        out_rf_r   <= res_rf_r;
        out_pa_r   <= res_pa_r;
        out_used_r <= USED_W'(cnt_r);
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_page_address = out_pa_r;
  assign out_range_free   = out_rf_r;
  assign out_used_pages   = out_used_r;

endmodule

/* src/buddy_page_allocator.sv */
// Work per request is data dependent: an alloc scans orders and splits its block down, a free
// walks the free list at each merge level, and a rejected request goes straight to the result.
// Reset-all sweeps every page and then carves the managed pages into blocks.
// One request is in work at a time; the result register lets the next request enter while
// a result is still waiting. After rst_n the block is not ready until a reset-all request.
module buddy_page_allocator import bpa_pkg::*; #(
  parameter int unsigned MAX_PAGES  = MAX_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = PAGE_SHIFT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [ADDR_W-1:0]  in_free_address,
  input  logic [PIDX_W-1:0]  in_first_page,
  input  logic [PIDX_W-1:0]  in_page_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic [PADDR_W-1:0] out_page_address,
  output logic               out_range_free,
  output logic [USED_W-1:0]  out_used_pages
);

  // The controller sequences each request as a series of datapath operations.
  // The datapath holds the free list heads in flip-flops and the per-page links,
  // orders and used flags in memories with one write port and one registered
  // read port, so every list step reads in one state and uses the data in the next.
  dp_op_t    op;
  bpa_stat_t stat;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .op       (op)
  );

  bpa_dp #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_cmd           (in_cmd),
    .in_free_address  (in_free_address),
    .in_first_page    (in_first_page),
    .in_page_count    (in_page_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ok           (out_ok),
    .out_page_address (out_page_address),
    .out_range_free   (out_range_free),
    .out_used_pages   (out_used_pages)
  );

endmodule
